/* hdl/char_range_expander_top_macros.svh */
`ifndef CHAR_RANGE_EXPANDER_TOP_MACROS_SVH
`define CHAR_RANGE_EXPANDER_TOP_MACROS_SVH

// checked only out of reset
`define CRX_ASSERT(lbl, ck, rn, prop) \
  lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error("crx assertion failed");

// checked in reset too
`define CRX_ASSERT_RST(lbl, ck, prop) \
  lbl: assert property (@(posedge ck) prop) else $error("crx reset assertion failed");

`endif

/* hdl/crx_pkg.sv */
package crx_pkg;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [7:0] CH_LO_A = 8'h61;
  localparam logic [7:0] CH_LO_Z = 8'h7A;
  localparam logic [7:0] CH_UP_A = 8'h41;
  localparam logic [7:0] CH_UP_Z = 8'h5A;
  localparam logic [7:0] CH_D0   = 8'h30;
  localparam logic [7:0] CH_D9   = 8'h39;
  localparam logic [7:0] CH_DASH = 8'h2D;

  typedef enum logic [1:0] {
    CLS_OTHER = 2'd0,
    CLS_LOWER = 2'd1,
    CLS_UPPER = 2'd2,
    CLS_DIGIT = 2'd3
  } cls_t;

  typedef struct packed {
    logic [7:0] in_char;
    logic       is_final;
  } in_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       run_end;
  } out_t;

  // optional leading '-', then every byte from lo up to hi
  typedef struct packed {
    logic       pre_dash;
    logic [7:0] lo;
    logic [7:0] hi;
  } job_t;

  function automatic cls_t char_class(input logic [7:0] c);
    cls_t r;
    r = CLS_OTHER;
    if (c >= CH_LO_A && c <= CH_LO_Z) begin
      r = CLS_LOWER;
    end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
      r = CLS_UPPER;
    end else if (c >= CH_D0 && c <= CH_D9) begin
      r = CLS_DIGIT;
    end
    return r;
  endfunction

endpackage

/* hdl/crx_front.sv */
module crx_front
  import crx_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  input  logic q_full,
  output logic push,
  output job_t push_job
);

  logic [7:0] prior_char_r, prior_char_nxt;
  logic       prior_alnum_r, prior_alnum_nxt;
  logic       dash_held_r, dash_held_nxt;
  logic       need_push;
  cls_t       cls;
  logic       accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign push     = accept && need_push;

  always_comb begin
    cls             = char_class(in_data.in_char);
    need_push       = 1'b0;
    push_job        = '{pre_dash: 1'b0, lo: in_data.in_char, hi: in_data.in_char};
    prior_char_nxt  = prior_char_r;
    prior_alnum_nxt = prior_alnum_r;
    dash_held_nxt   = dash_held_r;
    if (cls != CLS_OTHER) begin
      if (dash_held_r) begin
        if (char_class(prior_char_r) == cls && in_data.in_char >= prior_char_r) begin
          need_push   = (in_data.in_char != prior_char_r);
          push_job.lo = prior_char_r + 8'd1;
        end else begin
          need_push         = 1'b1;
          push_job.pre_dash = 1'b1;
        end
      end else begin
        need_push = 1'b1;
      end
      dash_held_nxt   = 1'b0;
      prior_alnum_nxt = 1'b1;
      prior_char_nxt  = in_data.in_char;
    end else if (in_data.in_char == CH_DASH) begin
      if (dash_held_r) begin
        need_push         = 1'b1;
        push_job.pre_dash = 1'b1;
        dash_held_nxt     = 1'b0;
      end else if (prior_alnum_r && !in_data.is_final) begin
        dash_held_nxt = 1'b1;
      end else begin
        need_push = 1'b1;
      end
      prior_alnum_nxt = 1'b0;
    end else begin
      need_push         = 1'b1;
      push_job.pre_dash = dash_held_r;
      dash_held_nxt     = 1'b0;
      prior_alnum_nxt   = 1'b0;
    end
    if (in_data.is_final) begin
      prior_char_nxt  = 8'd0;
      prior_alnum_nxt = 1'b0;
      dash_held_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prior_char_r  <= 8'd0;
      prior_alnum_r <= 1'b0;
      dash_held_r   <= 1'b0;
    end else if (accept) begin
      prior_char_r  <= prior_char_nxt;
      prior_alnum_r <= prior_alnum_nxt;
      dash_held_r   <= dash_held_nxt;
    end
  end

endmodule

/* hdl/crx_queue.sv */
module crx_queue
  import crx_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic q_valid,
  output job_t head
);

  job_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_push, do_pop;

  assign full    = (count_r == QCNT_W'(QDEPTH));
  assign q_valid = (count_r != '0);
  assign head    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

/* hdl/crx_back.sv */
module crx_back
  import crx_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic q_valid,
  input  job_t head,
  output logic pop,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  logic       busy_r;
  logic       dash_pend_r;
  logic [7:0] cur_r;
  logic [7:0] hi_r;
  logic       last;
  logic       take;

  assign last      = !dash_pend_r && (cur_r == hi_r);
  assign take      = out_valid && out_ready;
  assign pop       = q_valid && (!busy_r || (take && last));
  assign out_valid = busy_r;
  assign out_data  = '{out_char: dash_pend_r ? CH_DASH : cur_r, run_end: last};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      dash_pend_r <= 1'b0;
    end else if (pop) begin
      busy_r      <= 1'b1;
      dash_pend_r <= head.pre_dash;
    end else if (take) begin
      if (last) begin
        busy_r <= 1'b0;
      end
      dash_pend_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r <= head.lo;
      hi_r  <= head.hi;
    end else if (take && !dash_pend_r && !last) begin
      cur_r <= cur_r + 8'd1;
    end
  end

endmodule

/* hdl/char_range_expander_top.sv */
// Character range expander. Takes one byte per request with an end-of-string
// flag and expands shorthand such as a-z, D-K or 0-9; everything else passes
// through literally, and run_end marks the last output byte of each queued job.
// The front end classifies a byte in the cycle it is taken and queues a job
// (two deep) for the back end. The back end emits one byte per cycle while
// out_ready is high, and a job gives these bytes:
// - a plain byte gives itself;
// - a held hyphen goes out first, ahead of it;
// - a range gives one byte per added byte, up to 25;
// - an empty range gives none.
// The input stalls only while the job queue is full. No reset sweep is needed.
module char_range_expander_top
  import crx_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  logic push, q_full, q_valid, pop;
  job_t push_job, head;

  crx_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .push     (push),
    .push_job (push_job)
  );

  crx_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .q_valid  (q_valid),
    .head     (head)
  );

  crx_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

/* hdl/crx_checker.sv */
`include "char_range_expander_top_macros.svh"

module crx_checker
  import crx_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input in_t  in_data,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);

  `CRX_ASSERT_RST(a_rst_idle, clk, !rst_n |=> !out_valid)
  `CRX_ASSERT(a_in_hold, clk, rst_n, in_valid && !in_ready |=> in_valid && $stable(in_data))
  `CRX_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_data))
  `CRX_ASSERT(a_run_cont, clk, rst_n, out_valid && out_ready && !out_data.run_end |=> out_valid)

endmodule

bind char_range_expander_top crx_checker u_chk (.*);
